// ===== hdl/sorted_key_merge_accumulator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key merge accumulator
// Same-cycle and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_MERGE_ACCUMULATOR_UNIT_ASSERT_SVH
`define SORTED_KEY_MERGE_ACCUMULATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SKMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SKMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/skma_pkg.sv =====
// ----------------------------------------------------------------------------
// skma_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skma_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int COUNT_W   = 16;
	localparam int SUM_W     = 48;
	localparam int TOL_W     = 16;
	localparam int RIDX_W    = 8;
	localparam int OIDX_W    = 8;
	localparam int USED_W    = 9;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TOL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_TOL = 1'b1;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_MERGED    = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_READ_OK   = 3'd4,
		ST_READ_OOR  = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic    take_item;
		logic    scan_rd;
		logic    idx_inc;
		logic    shift_init;
		logic    shift_rd;
		logic    shift_wr;
		logic    merge_wr;
		logic    new_wr;
		logic    read_rd;
		logic    clear_used;
		logic    res_load;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              scan_end;
		logic              passed;
		logic              mergeable;
		logic              full;
		logic              shift_done;
		logic              at_end;
		logic              read_ok;
	} sts_t;

endpackage

// ===== hdl/sorted_key_merge_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_merge_accumulator_unit
// Sorted key table with merge-or-insert accumulation, read and clear.
// ----------------------------------------------------------------------------
// The table lives in one single-port-write, registered-read memory and is
// worked through one entry at a time by a sequencer, so an item's latency
// depends on table contents. An add walks past entries whose keys lie more
// than the skip tolerance below its key, then merges into the entry it
// stopped at if within the merge tolerance, or else moves the later entries
// up one by one to open a slot and inserts or appends; a full table drops
// it. A read fetches one entry, a clear empties the table, and an item with
// the unused mode is discarded without a result. The next item is taken
// once the current one has reached the output register, which holds
// a finished result until it is taken. Configuration writes are accepted
// every cycle and must only be issued while the unit is idle.
`timescale 1ns / 1ps

module sorted_key_merge_accumulator_unit
	import skma_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [MODE_W-1:0]       mode,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	input  logic [RIDX_W-1:0]       read_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [OIDX_W-1:0]       entry_index,
	output logic [KEY_W-1:0]        entry_key,
	output logic [COUNT_W-1:0]      entry_count,
	output logic signed [SUM_W-1:0] entry_sum,
	output logic [USED_W-1:0]       entries_used,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [TOL_W-1:0]        cfg_data
);

	cmd_t    cmd;
	sts_t    sts;
	status_t status_e;

	assign cfg_ready = 1'b1;
	assign status    = status_e;

	skma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skma_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.key          (key),
		.value        (value),
		.read_index   (read_index),
		.status       (status_e),
		.entry_index  (entry_index),
		.entry_key    (entry_key),
		.entry_count  (entry_count),
		.entry_sum    (entry_sum),
		.entries_used (entries_used)
	);

endmodule

// ===== hdl/skma_dp.sv =====
// ----------------------------------------------------------------------------
// skma_dp
// Entry memory, walk and shift pointers, tolerance registers, merge
// arithmetic and the result/output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_key_merge_accumulator_unit_assert.svh"

module skma_dp
	import skma_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TOL_W-1:0]      cfg_data,
	input  logic [MODE_W-1:0]     mode,
	input  logic [KEY_W-1:0]      key,
	input  logic signed [VAL_W-1:0] value,
	input  logic [RIDX_W-1:0]     read_index,
	output status_t               status,
	output logic [OIDX_W-1:0]     entry_index,
	output logic [KEY_W-1:0]      entry_key,
	output logic [COUNT_W-1:0]    entry_count,
	output logic signed [SUM_W-1:0] entry_sum,
	output logic [USED_W-1:0]     entries_used
);

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	logic [TOL_W-1:0]  skip_tol_q, merge_tol_q;
	logic [CNT_W-1:0]  used_q, idx_q, sp_q;
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [RIDX_W-1:0] ridx_q;

	status_t            res_status_q;
	logic [OIDX_W-1:0]  res_index_q;
	logic [KEY_W-1:0]   res_key_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [SUM_W-1:0]   res_sum_q;

	status_t            out_status_q;
	logic [OIDX_W-1:0]  out_index_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [SUM_W-1:0]   out_sum_q;
	logic [USED_W-1:0]  out_used_q;

	logic [CNT_W-1:0]  sp_m1;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	logic              mem_we, mem_re;
	entry_t            wr_data, merged, fresh;
	logic [KEY_W:0]    key_thresh;
	logic [KEY_W-1:0]  key_diff;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  value_ext;

	assign sp_m1     = sp_q - CNT_W'(1);
	assign value_ext = {{(SUM_W-VAL_W){value_q[VAL_W-1]}}, value_q};

	// walk and merge tests on the entry just read
	always_comb begin
		key_thresh = {1'b0, rd_q.key} + (KEY_W+1)'(skip_tol_q);
		key_diff   = (rd_q.key > key_q) ? (rd_q.key - key_q) : (key_q - rd_q.key);
	end

	always_comb begin
		sum_wide = {rd_q.sum[SUM_W-1], rd_q.sum} + {value_ext[SUM_W-1], value_ext};
		merged.key   = rd_q.key;
		merged.count = (rd_q.count == {COUNT_W{1'b1}}) ? rd_q.count
			: rd_q.count + COUNT_W'(1);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			merged.sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			merged.sum = sum_wide[SUM_W-1:0];
		end
		fresh.key   = key_q;
		fresh.count = COUNT_W'(1);
		fresh.sum   = value_ext;
	end

	always_comb begin
		sts.mode       = mode_q;
		sts.scan_end   = (idx_q >= used_q);
		sts.passed     = ({1'b0, key_q} > key_thresh);
		sts.mergeable  = (key_diff <= KEY_W'(merge_tol_q));
		sts.full       = (used_q >= CNT_W'(TABLE_DEPTH));
		sts.shift_done = (sp_q <= idx_q);
		sts.at_end     = (idx_q == used_q);
		sts.read_ok    = (32'(ridx_q) < 32'(used_q));
	end

	// memory port selection
	always_comb begin
		mem_re  = cmd.scan_rd | cmd.shift_rd | cmd.read_rd;
		mem_we  = cmd.shift_wr | cmd.merge_wr | cmd.new_wr;
		rd_addr = idx_q[IDX_W-1:0];
		if (cmd.shift_rd) begin
			rd_addr = sp_m1[IDX_W-1:0];
		end else if (cmd.read_rd) begin
			rd_addr = IDX_W'(ridx_q);
		end
		wr_addr = cmd.shift_wr ? sp_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		if (cmd.shift_wr) begin
			wr_data = rd_q;
		end else if (cmd.merge_wr) begin
			wr_data = merged;
		end else begin
			wr_data = fresh;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_tol_q  <= '0;
			merge_tol_q <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			sp_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SKIP_TOL:  skip_tol_q  <= cfg_data;
					CFG_MERGE_TOL: merge_tol_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.take_item) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.shift_init) begin
				sp_q <= used_q;
			end else if (cmd.shift_wr) begin
				sp_q <= sp_m1;
			end
			if (cmd.clear_used) begin
				used_q <= '0;
			end else if (cmd.new_wr) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
			ridx_q  <= read_index;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_status)
				ST_MERGED: begin
					res_index_q <= OIDX_W'(idx_q);
					res_key_q   <= merged.key;
					res_count_q <= merged.count;
					res_sum_q   <= merged.sum;
				end
				ST_APPENDED, ST_INSERTED: begin
					res_index_q <= OIDX_W'(idx_q);
					res_key_q   <= fresh.key;
					res_count_q <= fresh.count;
					res_sum_q   <= fresh.sum;
				end
				ST_READ_OK: begin
					res_index_q <= OIDX_W'(ridx_q);
					res_key_q   <= rd_q.key;
					res_count_q <= rd_q.count;
					res_sum_q   <= rd_q.sum;
				end
				ST_READ_OOR: begin
					res_index_q <= OIDX_W'(ridx_q);
					res_key_q   <= '0;
					res_count_q <= '0;
					res_sum_q   <= '0;
				end
				default: begin
					res_index_q <= '0;
					res_key_q   <= '0;
					res_count_q <= '0;
					res_sum_q   <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_key_q    <= res_key_q;
			out_count_q  <= res_count_q;
			out_sum_q    <= res_sum_q;
			out_used_q   <= USED_W'(used_q);
		end
	end

	assign status       = out_status_q;
	assign entry_index  = out_index_q;
	assign entry_key    = out_key_q;
	assign entry_count  = out_count_q;
	assign entry_sum    = out_sum_q;
	assign entries_used = out_used_q;

	`SKMA_ASSERT_NOW(a_used_bound, 1'b1, used_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
	`SKMA_ASSERT_NOW(a_new_not_full, cmd.new_wr, !sts.full, "new entry written into full table")
	`SKMA_ASSERT_NOW(a_shift_range, cmd.shift_wr, (sp_q > idx_q) && (sp_q <= used_q), "shift out of range")
	`SKMA_ASSERT_NEXT(a_new_count, cmd.new_wr && !cmd.clear_used, used_q == $past(used_q) + CNT_W'(1), "entry count not advanced")

endmodule

// ===== hdl/skma_ctrl.sv =====
// ----------------------------------------------------------------------------
// skma_ctrl
// Sequencer for add/read/clear: walks the table, merges, or shifts and
// inserts (or drops when full), then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skma_ctrl
	import skma_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_EVAL,
		S_MERGE,
		S_PLACE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.res_status = ST_CLEARED;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					MODE_ADD: state_d = S_SCAN;
					MODE_READ: begin
						if (sts.read_ok) begin
							cmd.read_rd = 1'b1;
							state_d = S_READ;
						end else begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_READ_OOR;
							state_d = S_DONE;
						end
					end
					MODE_CLEAR: begin
						cmd.clear_used = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_CLEARED;
						state_d = S_DONE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_PLACE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.passed) begin
					cmd.idx_inc = 1'b1;
					state_d = S_SCAN;
				end else if (sts.mergeable) begin
					state_d = S_MERGE;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_MERGE: begin
				cmd.merge_wr   = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_MERGED;
				state_d = S_DONE;
			end
			S_PLACE: begin
				if (sts.full) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_DROPPED;
					state_d = S_DONE;
				end else begin
					cmd.shift_init = 1'b1;
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (sts.shift_done) begin
					cmd.new_wr     = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_status = sts.at_end ? ST_APPENDED : ST_INSERTED;
					state_d = S_DONE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_READ: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_READ_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
